FILE: sv/qpht_pkg.sv
// constants and codes for the quadratic probe hash table
// used by the top level and by its port checker; depends on nothing
`default_nettype none

package qpht_pkg;

   localparam int TABLE_SLOTS_DEF = 256;
   localparam int KEY_BITS_DEF    = 32;
   localparam int VALUE_BITS_DEF  = 64;

   localparam int KEY_ID_W    = 32;
   localparam int HASH_W      = 32;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 2;
   localparam int SLOT_W      = 8;
   localparam int REQ_DATA_W  = KEY_ID_W + HASH_W + VALUE_W;
   localparam int RSP_DATA_W  = SLOT_W + VALUE_W;

   localparam int CFG_W = 9;
   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 9'd256;

   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = HASH_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

`default_nettype wire

FILE: sv/quadratic_probe_hash_table_top.sv
// open-addressing key/value table with quadratic probing over one slot memory
// depends on qpht_pkg
//
// usage:
//   req channel: one word per operation; req_tuser is the action (lookup or
//   insert), req_tdata carries key id, key hash and value.
//   rsp channel: one word per operation; rsp_tuser is the status, rsp_tdata
//   carries the slot and the looked-up value.
//   csr port: table size; the user writes it only while the block is idle (not enforced).
// operation:
//   one operation at a time. accept, hash mod size (8 bits a cycle), one read
//   issue, one probe per cycle through the slot memory, then hand-off of the
//   result to the output register.
//   the next word is taken in the cycle after the result leaves the core.
// reset:
//   a clearing pass writes every slot empty, with req
//   held off; table size returns to 256.
// stall:
//   rsp is a registered output; a finished result waits in the core until the
//   output register frees, and req stays held off meanwhile.
`default_nettype none

module quadratic_probe_hash_table_top #(
   parameter int TABLE_SLOTS = qpht_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BITS    = qpht_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS  = qpht_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // key_id[31:0], key_hash[63:32], value[127:64]
   input  wire logic [qpht_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // slot[7:0], value_out[71:8]
   output logic [qpht_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // status
   output logic [qpht_pkg::STATUS_W-1:0]          rsp_tuser,
   input  wire logic                              csr_wr_en,
   input  wire logic [qpht_pkg::CFG_W-1:0]        csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int MEM_W = 1 + KEY_BITS + VALUE_BITS;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_ISSUE = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [qpht_pkg::CFG_W-1:0] table_size_ff;
   logic [CNT_W-1:0]           size_n;

   logic                         insert_ff, insert_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic [VALUE_BITS-1:0]        val_ff, val_in;
   logic [qpht_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [CNT_W-1:0]             rem_ff, rem_in, rem_next;
   logic [qpht_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] probe_ff, probe_in;
   logic [IDX_W-1:0] chk_pos_ff, chk_pos_in;
   logic             chk_last_ff, chk_last_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   logic [qpht_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0]              res_slot_ff, res_slot_in;
   logic [VALUE_BITS-1:0]         res_value_ff, res_value_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [qpht_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [qpht_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [MEM_W-1:0] table_mem [TABLE_SLOTS];
   logic [MEM_W-1:0] rd_word_ff;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_wa;
   logic [MEM_W-1:0] mem_wd;

   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   logic [IDX_W:0] pos_sum, step_sum, size_ext;

   assign rd_valid = rd_word_ff[MEM_W-1];
   assign rd_key   = rd_word_ff[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
   assign rd_value = rd_word_ff[VALUE_BITS-1:0];

   // active size, clamped to 1..TABLE_SLOTS
   always_comb begin
      if (table_size_ff > TABLE_SLOTS) begin
         size_n = CNT_W'(TABLE_SLOTS);
      end else if (table_size_ff == '0) begin
         size_n = CNT_W'(1);
      end else begin
         size_n = CNT_W'(table_size_ff);
      end
   end

   // hash mod size, DIV_BITS restoring steps per cycle
   always_comb begin
      logic [CNT_W:0] r;
      r = {1'b0, rem_ff};
      for (int b = 0; b < qpht_pkg::DIV_BITS; b++) begin
         r = {r[CNT_W-1:0], hash_ff[qpht_pkg::HASH_W-1-b]};
         if (r >= {1'b0, size_n}) begin
            r = r - {1'b0, size_n};
         end
      end
      rem_next = r[CNT_W-1:0];
   end

   // incremental (hash + i*i) mod size: pos += step, step += 2
   assign size_ext = (IDX_W+1)'(size_n);
   always_comb begin
      pos_sum  = {1'b0, pos_ff} + {1'b0, step_ff};
      if (pos_sum >= size_ext) begin
         pos_sum = pos_sum - size_ext;
      end
      step_sum = {1'b0, step_ff} + (IDX_W+1)'(2);
      if (step_sum >= size_ext) begin
         step_sum = step_sum - size_ext;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      logic hit_empty, hit_key, out_free;
      hit_empty = !rd_valid;
      hit_key   = rd_valid && (rd_key == key_ff);
      out_free  = !rsp_valid_ff || rsp_tready;

      state_in      = state_ff;
      insert_in     = insert_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      hash_in       = hash_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      probe_in      = probe_ff;
      chk_pos_in    = chk_pos_ff;
      chk_last_in   = chk_last_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = chk_pos_ff;
      mem_wd        = {1'b1, key_ff, val_ff};
      mem_re        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               insert_in  = req_tuser;
               key_in     = KEY_BITS'(req_tdata[qpht_pkg::KEY_ID_W-1:0]);
               hash_in    = req_tdata[qpht_pkg::KEY_ID_W+qpht_pkg::HASH_W-1:
                                      qpht_pkg::KEY_ID_W];
               val_in     = VALUE_BITS'(req_tdata[qpht_pkg::REQ_DATA_W-1:
                                                  qpht_pkg::KEY_ID_W+qpht_pkg::HASH_W]);
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            rem_in     = rem_next;
            hash_in    = hash_ff << qpht_pkg::DIV_BITS;
            div_cnt_in = div_cnt_ff + qpht_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == qpht_pkg::DIV_CNT_W'(qpht_pkg::DIV_STEPS - 1)) begin
               pos_in   = IDX_W'(rem_next);
               step_in  = (size_n == CNT_W'(1)) ? '0 : IDX_W'(1);
               probe_in = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            mem_re      = 1'b1;
            chk_pos_in  = pos_ff;
            chk_last_in = (probe_ff == size_n - CNT_W'(1));
            pos_in      = pos_sum[IDX_W-1:0];
            step_in     = step_sum[IDX_W-1:0];
            probe_in    = probe_ff + CNT_W'(1);
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            res_slot_in  = '0;
            res_value_in = '0;
            if (hit_empty || hit_key) begin
               if (insert_ff == qpht_pkg::ACT_INSERT) begin
                  mem_we        = 1'b1;
                  res_status_in = qpht_pkg::STATUS_OK;
                  res_slot_in   = chk_pos_ff;
               end else if (hit_key) begin
                  res_status_in = qpht_pkg::STATUS_OK;
                  res_slot_in   = chk_pos_ff;
                  res_value_in  = rd_value;
               end else begin
                  res_status_in = qpht_pkg::STATUS_NOT_FOUND;
               end
               state_in = S_DONE;
            end else if (chk_last_ff) begin
               res_status_in = (insert_ff == qpht_pkg::ACT_INSERT) ?
                               qpht_pkg::STATUS_FULL : qpht_pkg::STATUS_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               mem_re      = 1'b1;
               chk_pos_in  = pos_ff;
               chk_last_in = (probe_ff == size_n - CNT_W'(1));
               pos_in      = pos_sum[IDX_W-1:0];
               step_in     = step_sum[IDX_W-1:0];
               probe_in    = probe_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = {qpht_pkg::VALUE_W'(res_value_ff),
                                qpht_pkg::SLOT_W'(res_slot_ff)};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= qpht_pkg::TABLE_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            table_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      insert_ff     <= insert_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      hash_ff       <= hash_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      probe_ff      <= probe_in;
      chk_pos_ff    <= chk_pos_in;
      chk_last_ff   <= chk_last_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_word_ff <= table_mem[pos_ff];
      end
   end

endmodule

`default_nettype wire

FILE: sv/qpht_checker.sv
// port-level checks for the quadratic probe hash table, bound to the top level
// depends on qpht_pkg and quadratic_probe_hash_table_top
`default_nettype none

module qpht_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [qpht_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [qpht_pkg::STATUS_W-1:0]     rsp_tuser
);

   // one operation in the core at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again right after accept");

   // clearing pass holds off requests after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("req ready during clearing pass");

   // a failed operation returns slot and value as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != qpht_pkg::STATUS_OK |-> rsp_tdata == '0)
      else $error("nonzero payload on failed operation");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == qpht_pkg::STATUS_OK ||
                     rsp_tuser == qpht_pkg::STATUS_NOT_FOUND ||
                     rsp_tuser == qpht_pkg::STATUS_FULL)
      else $error("undefined status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser))
      else $error("stalled rsp word changed");

endmodule

bind quadratic_probe_hash_table_top qpht_checker u_qpht_checker (.*);

`default_nettype wire

FILE: tb/probe_check_pkg.sv
// scoreboard for the quadratic probe hash table testbench: a private copy of the
// slot table that predicts each answer, and a queue of the answers still awaited
// depends on qpht_pkg
package probe_check_pkg;

   import qpht_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  value_out;
   } table_answer_type;

   class probe_scoreboard;

      bit                  slot_used [TABLE_SLOTS_DEF];
      logic [KEY_ID_W-1:0] slot_key  [TABLE_SLOTS_DEF];
      logic [VALUE_W-1:0]  slot_data [TABLE_SLOTS_DEF];
      logic [CFG_W-1:0]    table_size;
      table_answer_type    awaited_answers [$];
      int unsigned         failures;

      function new();
         table_size = TABLE_SIZE_RESET;
         failures   = 0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      function void set_table_size(logic [CFG_W-1:0] size);
         table_size = size;
      endfunction

      function int unsigned pending();
         return awaited_answers.size();
      endfunction

      function void note_operation(logic action, logic [KEY_ID_W-1:0] key,
                                   logic [HASH_W-1:0] hash, logic [VALUE_W-1:0] value);
         table_answer_type answer;
         int unsigned   span;
         int unsigned   i;
         int unsigned   idx;
         logic [63:0]   probe;
         bit            done;
         span = table_size;
         if (span == 0)
            span = 1;
         if (span > TABLE_SLOTS_DEF)
            span = TABLE_SLOTS_DEF;
         answer.status    = (action == ACT_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
         answer.slot      = '0;
         answer.value_out = '0;
         done = 1'b0;
         for (i = 0; i < span && !done; i++) begin
            probe = ({32'd0, hash} + 64'(i) * 64'(i)) % 64'(span);
            idx   = int'(probe);
            if (!slot_used[idx]) begin
               if (action == ACT_INSERT) begin
                  slot_used[idx]   = 1'b1;
                  slot_key[idx]    = key;
                  slot_data[idx]   = value;
                  answer.status    = STATUS_OK;
                  answer.slot      = idx[SLOT_W-1:0];
               end
               done = 1'b1;
            end else if (slot_key[idx] == key) begin
               answer.status = STATUS_OK;
               answer.slot   = idx[SLOT_W-1:0];
               if (action == ACT_INSERT)
                  slot_data[idx] = value;
               else
                  answer.value_out = slot_data[idx];
               done = 1'b1;
            end
         end
         awaited_answers.push_back(answer);
      endfunction

      function void check_answer(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                 logic [VALUE_W-1:0] value_out);
         table_answer_type want;
         if (awaited_answers.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected word: status %0d slot %0d value %h", status, slot,
                        value_out);
            return;
         end
         want = awaited_answers.pop_front();
         if (want.status !== status || want.slot !== slot ||
             want.value_out !== value_out) begin
            failures++;
            if (failures <= 10)
               $display({"mismatch: expected status %0d slot %0d value %h, ",
                         "got status %0d slot %0d value %h"},
                        want.status, want.slot, want.value_out, status, slot, value_out);
         end
      endfunction

   endclass

endpackage

FILE: tb/testbench.sv
// testbench for quadratic_probe_hash_table_top: directed and random lookups and
// inserts over several table sizes, with bursty input and a stalling receiver
// depends on qpht_pkg and probe_check_pkg
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import qpht_pkg::*;
   import probe_check_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 300;
   localparam int PHASES           = 16;
   localparam int PHASE_ITEMS      = 120;
   localparam int POOL             = 16;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = ACT_LOOKUP;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   probe_scoreboard sb;

   bit          sender_gaps   = 1'b0;
   bit          ready_stalls  = 1'b0;
   int unsigned burst_left    = 0;
   int unsigned holds_asked   = 0;
   int unsigned holds_given   = 0;
   int unsigned hold_left     = 0;
   int unsigned run_left      = 0;
   bit          run_ready     = 1'b0;
   int unsigned quiet_cycles  = 0;

   quadratic_probe_hash_table_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         run_left  = 0;
      end else if (holds_given != holds_asked) begin
         holds_given = holds_asked;
         hold_left   = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!ready_stalls) begin
         rsp_tready <= 1'b1;
      end else begin
         if (run_left == 0) begin
            run_ready = !run_ready;
            run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
         end
         run_left--;
         rsp_tready <= run_ready;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_answer(rsp_tuser, rsp_tdata[SLOT_W-1:0],
                            rsp_tdata[SLOT_W+VALUE_W-1:SLOT_W]);
         if (req_tvalid && req_tready)
            sb.note_operation(req_tuser, req_tdata[KEY_ID_W-1:0],
                              req_tdata[KEY_ID_W+HASH_W-1:KEY_ID_W],
                              req_tdata[REQ_DATA_W-1:KEY_ID_W+HASH_W]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_word(input logic action, input logic [KEY_ID_W-1:0] key,
                            input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] value);
      if (sender_gaps) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {value, hash, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // let the block go idle before touching the size register
   task automatic settle();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [CFG_W-1:0] size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_table_size(size);
   endtask

   initial begin
      logic [CFG_W-1:0]    phase_sizes [PHASES];
      logic [KEY_ID_W-1:0] pool_key    [POOL];
      logic [HASH_W-1:0]   pool_hash   [POOL];
      logic [KEY_ID_W-1:0] key;
      logic [HASH_W-1:0]   hash;
      logic                action;
      int unsigned         phase;
      int unsigned         item;
      int unsigned         pick;
      int unsigned         j;

      sb = new();
      phase_sizes = '{9'd1, 9'd0, 9'd2, 9'd511, 9'd3, 9'd13, 9'd257, 9'd32,
                      9'd7, 9'd64, 9'd100, 9'd256, 9'd16, 9'd128, 9'd5, 9'd40};
      foreach (pool_key[i]) begin
         pool_key[i]  = $urandom;
         pool_hash[i] = $urandom;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset size, collisions, overwrite and a miss past a collision chain
      send_word(ACT_LOOKUP, 32'h0, 32'h0, '1);
      send_word(ACT_INSERT, 32'h0, 32'h0, '1);
      send_word(ACT_LOOKUP, 32'h0, 32'h0, '0);
      send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
      send_word(ACT_INSERT, 32'h5, 32'h0, 64'h0123_4567_89AB_CDEF);
      send_word(ACT_INSERT, 32'h6, 32'h0, 64'hFEDC_BA98_7654_3210);
      send_word(ACT_LOOKUP, 32'h6, 32'h0, '0);
      send_word(ACT_INSERT, 32'h5, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0);
      send_word(ACT_LOOKUP, 32'h5, 32'h0, '1);
      send_word(ACT_LOOKUP, 32'h7, 32'h0, '0);
      settle();

      // one slot: full table, miss, overwrite
      write_table_size(9'd1);
      send_word(ACT_INSERT, 32'h11, 32'h7, '1);
      send_word(ACT_LOOKUP, 32'h11, 32'h7, '0);
      send_word(ACT_INSERT, 32'h0, 32'hFFFF_FFFF, 64'h1357_9BDF_2468_ACE0);
      send_word(ACT_LOOKUP, 32'h0, 32'h3, '0);
      settle();
      write_table_size(9'd0);
      send_word(ACT_LOOKUP, 32'h0, 32'h9, '0);
      send_word(ACT_INSERT, 32'h12, 32'h0, '0);
      settle();
      write_table_size(9'd511);
      send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
      settle();
      write_table_size(9'd257);
      send_word(ACT_LOOKUP, 32'h6, 32'h0, '0);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         write_table_size(phase_sizes[phase]);
         sender_gaps  = (phase % 4) != 3;
         ready_stalls = (phase % 3) != 2;
         for (j = 0; j < 4; j++) begin
            pick = $urandom_range(0, POOL - 1);
            pool_key[pick]  = $urandom;
            pool_hash[pick] = $urandom;
         end
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if ((phase == 4 || phase == 9) && item == 20)
               holds_asked++;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               j    = $urandom_range(0, POOL - 1);
               key  = pool_key[j];
               hash = pool_hash[j];
            end else if (pick < 80) begin
               key  = pool_key[$urandom_range(0, POOL - 1)];
               hash = $urandom;
            end else begin
               key  = $urandom;
               hash = $urandom;
            end
            action = $urandom_range(0, 1) ? ACT_INSERT : ACT_LOOKUP;
            send_word(action, key, hash, {$urandom, $urandom});
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
